>>> design/mailbox_doorbell_registers_unit_assert.svh
// Assertion macros for the mailbox doorbell register block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MAILBOX_DOORBELL_REGISTERS_UNIT_ASSERT_SVH
`define MAILBOX_DOORBELL_REGISTERS_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MDR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mailbox doorbell assertion failed");

// Next-cycle implication, off while reset is asserted.
`define MDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mailbox doorbell assertion failed");

`endif

>>> design/mdr_pkg.sv
// Shared types and opcode constants for the mailbox doorbell register block.
// No dependencies.
`default_nettype none

package mdr_pkg;

	localparam logic [3:0] OP_READ_STATUS  = 4'd0;
	localparam logic [3:0] OP_SET_STATUS   = 4'd1;
	localparam logic [3:0] OP_CLEAR_STATUS = 4'd2;
	localparam logic [3:0] OP_SET_MASK     = 4'd3;
	localparam logic [3:0] OP_CLEAR_MASK   = 4'd4;
	localparam logic [3:0] OP_READ_MASK    = 4'd5;
	localparam logic [3:0] OP_WRITE_REQ    = 4'd6;
	localparam logic [3:0] OP_READ_READY   = 4'd7;
	localparam logic [3:0] OP_READ_COUNT   = 4'd8;

	// Highest channel index the 4-bit channel field can reach, plus one.
	localparam int INDEX_SPAN = 16;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [3:0]  channel_index;
		logic [31:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        interrupt_pending;
		logic        request_flag;
	} res_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

endpackage

`default_nettype wire

>>> design/mailbox_doorbell_registers_unit.sv
// Top level of the mailbox doorbell register block: controller plus datapath.
// Depends on mdr_pkg, mdr_ctrl, mdr_datapath and the assertion macro header.
//
//  channel | signals            | transfer when
//  --------+--------------------+------------------------------
//  access  | start, busy, cmd   | start high and busy low
//  result  | done, result       | every cycle done is high
//
// Each access has an execute step, the read-modify-write on the addressed
// status or mask word, and then a step with the result on the ports. A new
// access can be taken in the cycle the previous result is shown, but not
// while one is executing. Reset clears all status and mask words, the
// pending flags and the access request at once. The receiver cannot stall;
// busy is high only during the execute cycle.
`default_nettype none

`include "mailbox_doorbell_registers_unit_assert.svh"

module mailbox_doorbell_registers_unit
	import mdr_pkg::*;
#(
	parameter int CHANNELS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output res_t      result
);

	ctl_t ctl;

	// Sequence each access: latch, execute, present.
	mdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// Hold the channel words and build the result.
	mdr_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.result (result)
	);

	// Result strobe never overlaps the execute cycle.
	`MDR_ASSERT_SAME(a_done_not_busy, done, !busy)
	// An accepted access executes in the next cycle.
	`MDR_ASSERT_NEXT(a_accept_exec, start && !busy, busy)
	// Execution always ends in a result transfer.
	`MDR_ASSERT_NEXT(a_exec_done, busy, done)
	// A request write shows up on request_flag with its result.
	`MDR_ASSERT_NEXT(a_req_mirror, start && !busy && cmd.opcode == OP_WRITE_REQ,
		##1 (result.request_flag == $past(cmd.write_data[0], 2)))

endmodule

`default_nettype wire

>>> design/mdr_ctrl.sv
// Access sequencer for the mailbox doorbell register block.
// Depends on mdr_pkg for the ctl_t control struct.
`default_nettype none

module mdr_ctrl
	import mdr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output ctl_t      ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       accept;

	assign busy   = (state_q == ST_EXEC);
	assign done   = (state_q == ST_DONE);
	assign accept = start && !busy;

	assign ctl.load = accept;
	assign ctl.exec = busy;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				state_next = accept ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

>>> design/mdr_datapath.sv
// Channel status and mask storage with read-modify-write logic.
// Depends on mdr_pkg for payload types and opcodes.
`default_nettype none

module mdr_datapath
	import mdr_pkg::*;
#(
	parameter int CHANNELS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ctl_t ctl,
	input  wire cmd_t cmd,
	output res_t      result
);

	localparam int DEPTH = (CHANNELS < INDEX_SPAN) ? CHANNELS : INDEX_SPAN;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t             cmd_q;
	res_t             res_q;
	logic [31:0]      status_q [DEPTH];
	logic [31:0]      mask_q   [DEPTH];
	logic [DEPTH-1:0] pend_q;
	logic             req_q;

	logic [IW-1:0]    idx;
	logic             ch_ok;
	logic [31:0]      cur_s;
	logic [31:0]      cur_m;
	logic [31:0]      new_s;
	logic [31:0]      new_m;
	logic [31:0]      rd;
	logic             new_req;
	logic [DEPTH-1:0] pend_next;

	assign idx   = cmd_q.channel_index[IW-1:0];
	assign ch_ok = int'(cmd_q.channel_index) < CHANNELS;
	assign cur_s = ch_ok ? status_q[idx] : '0;
	assign cur_m = ch_ok ? mask_q[idx] : '0;

	always_comb begin
		new_s   = cur_s;
		new_m   = cur_m;
		new_req = req_q;
		rd      = '0;
		case (cmd_q.opcode)
			OP_READ_STATUS:  rd = cur_s;
			OP_SET_STATUS:   new_s = cur_s | cmd_q.write_data;
			OP_CLEAR_STATUS: new_s = cur_s & ~cmd_q.write_data;
			OP_SET_MASK:     new_m = cur_m | cmd_q.write_data;
			OP_CLEAR_MASK:   new_m = cur_m & ~cmd_q.write_data;
			OP_READ_MASK:    rd = cur_m;
			OP_WRITE_REQ:    new_req = cmd_q.write_data[0];
			OP_READ_READY:   rd = {31'b0, req_q};
			OP_READ_COUNT:   rd = 32'(CHANNELS);
			default:         rd = '0;
		endcase
	end

	// Per-channel pending flag tracks the written word's unmasked bits.
	always_comb begin
		pend_next = pend_q;
		if (ch_ok) pend_next[idx] = |(new_s & ~new_m);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) cmd_q <= cmd;
		if (ctl.exec) begin
			res_q.read_data         <= rd;
			res_q.interrupt_pending <= |pend_next;
			res_q.request_flag      <= new_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < DEPTH; c++) begin
				status_q[c] <= '0;
				mask_q[c]   <= '0;
			end
			pend_q <= '0;
			req_q  <= 1'b0;
		end else if (ctl.exec) begin
			if (ch_ok) begin
				status_q[idx] <= new_s;
				mask_q[idx]   <= new_m;
			end
			pend_q <= pend_next;
			req_q  <= new_req;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

>>> sim/mailbox_doorbell_registers_unit_tb.sv
// Self-checking testbench for the mailbox doorbell register block.
// Depends on mdr_pkg and mailbox_doorbell_registers_unit; predicts every
// access result with its own copy of the channel words and the request bit.
`default_nettype none

module mailbox_doorbell_registers_unit_tb;
	import mdr_pkg::*;

	localparam int NUM_CHANNELS = 16;
	localparam int RANDOM_ITEMS = 1880;
	// No transfer for this many cycles means the block has hung.
	localparam int IDLE_LIMIT = 400;
	// Cycles to keep watching once every result has come back.
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS = 40;
	localparam int MAX_GAP = 6;
	// Top of the opcode field; everything above OP_READ_COUNT is unused.
	localparam logic [3:0] OP_TOP = 4'hF;
	localparam logic [3:0] CH_TOP = 4'hF;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t result;

	// Predictor state: mirrors the block's channel words and request bit.
	logic [31:0] status_copy [NUM_CHANNELS];
	logic [31:0] mask_copy [NUM_CHANNELS];
	logic request_copy;

	// Results expected from the block, oldest first.
	res_t pending_replies [$];
	res_t want_reply;

	int error_count = 0;
	int idle_cycles = 0;
	// When set, the sender drives back-to-back accesses with no gaps.
	bit no_idle = 1'b0;

	mailbox_doorbell_registers_unit #(
		.CHANNELS(NUM_CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic cmd_t make_cmd(input logic [3:0] op, input logic [3:0] ch,
			input logic [31:0] data);
		cmd_t c;
		c.opcode = op;
		c.channel_index = ch;
		c.write_data = data;
		return c;
	endfunction

	// Apply one access to the predictor state and return what the block
	// must show afterwards. The pending flag and ready bit reflect the
	// state after the access.
	function automatic res_t apply_access(input cmd_t c);
		res_t r;
		logic [31:0] hit;
		logic ch_ok;
		ch_ok = (c.channel_index < NUM_CHANNELS);
		r.read_data = '0;
		case (c.opcode)
			OP_READ_STATUS: begin
				if (ch_ok) r.read_data = status_copy[c.channel_index];
			end
			OP_SET_STATUS: begin
				if (ch_ok) status_copy[c.channel_index] |= c.write_data;
			end
			OP_CLEAR_STATUS: begin
				if (ch_ok) status_copy[c.channel_index] &= ~c.write_data;
			end
			OP_SET_MASK: begin
				if (ch_ok) mask_copy[c.channel_index] |= c.write_data;
			end
			OP_CLEAR_MASK: begin
				if (ch_ok) mask_copy[c.channel_index] &= ~c.write_data;
			end
			OP_READ_MASK: begin
				if (ch_ok) r.read_data = mask_copy[c.channel_index];
			end
			OP_WRITE_REQ: begin
				request_copy = c.write_data[0];
			end
			OP_READ_READY: begin
				r.read_data = {31'b0, request_copy};
			end
			OP_READ_COUNT: begin
				r.read_data = 32'(NUM_CHANNELS);
			end
			default: begin
			end
		endcase
		hit = '0;
		for (int k = 0; k < NUM_CHANNELS; k++)
			hit |= status_copy[k] & ~mask_copy[k];
		r.interrupt_pending = |hit;
		r.request_flag = request_copy;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Send one access: idle for a random number of cycles (noise on cmd,
	// start low), then hold start until the block takes the transfer.
	task automatic send_access(input cmd_t c);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
			cmd = make_cmd(4'($urandom_range(0, OP_TOP)), 4'($urandom_range(0, CH_TOP)),
				$urandom);
		end
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		// Busy is sampled before the edge updates it, so the loop exits on
		// the edge that takes the transfer.
		do
			@(posedge clk);
		while (busy);
	endtask

	// Data shapes: full random, one bit, all ones, sparse bits.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		case ($urandom_range(0, 3))
			0: w = $urandom;
			1: w = 32'd1 << $urandom_range(0, 31);
			2: w = ALL_ONES;
			default: w = $urandom & $urandom & $urandom;
		endcase
		return w;
	endfunction

	// Weighted opcode pick: mostly status and mask traffic, a few of the rest.
	function automatic logic [3:0] random_opcode();
		int roll;
		logic [3:0] op;
		roll = $urandom_range(0, 99);
		if (roll < 20) op = OP_SET_STATUS;
		else if (roll < 35) op = OP_CLEAR_STATUS;
		else if (roll < 50) op = OP_READ_STATUS;
		else if (roll < 60) op = OP_SET_MASK;
		else if (roll < 70) op = OP_CLEAR_MASK;
		else if (roll < 80) op = OP_READ_MASK;
		else if (roll < 85) op = OP_WRITE_REQ;
		else if (roll < 90) op = OP_READ_READY;
		else if (roll < 93) op = OP_READ_COUNT;
		else op = 4'($urandom_range(OP_READ_COUNT + 1, OP_TOP));
		return op;
	endfunction

	// Reset values: sampled status and mask words zero, no request, count
	// readable, unused opcodes read as zero.
	task automatic test_after_reset();
		send_access(make_cmd(OP_READ_STATUS, 4'd0, ALL_ONES));
		send_access(make_cmd(OP_READ_STATUS, CH_TOP, 32'd0));
		send_access(make_cmd(OP_READ_MASK, 4'd7, ALL_ONES));
		send_access(make_cmd(OP_READ_READY, 4'd3, ALL_ONES));
		send_access(make_cmd(OP_READ_COUNT, CH_TOP, ALL_ONES));
		send_access(make_cmd(4'(OP_READ_COUNT + 1), 4'd2, ALL_ONES));
		send_access(make_cmd(OP_TOP, CH_TOP, ALL_ONES));
	endtask

	// Walk the interrupt through set, masked, partly unmasked and cleared.
	task automatic test_status_and_mask();
		send_access(make_cmd(OP_SET_STATUS, 4'd3, ALL_ONES));
		send_access(make_cmd(OP_READ_STATUS, 4'd3, 32'd0));
		send_access(make_cmd(OP_SET_MASK, 4'd3, ALL_ONES));
		send_access(make_cmd(OP_READ_MASK, 4'd3, 32'd0));
		send_access(make_cmd(OP_CLEAR_MASK, 4'd3, 32'h8000_0000));
		send_access(make_cmd(OP_CLEAR_STATUS, 4'd3, 32'h8000_0000));
		send_access(make_cmd(OP_SET_STATUS, CH_TOP, 32'd1));
		send_access(make_cmd(OP_CLEAR_STATUS, CH_TOP, ALL_ONES));
		send_access(make_cmd(OP_CLEAR_MASK, 4'd3, ALL_ONES));
		send_access(make_cmd(OP_READ_STATUS, 4'd3, ALL_ONES));
	endtask

	// Only bit 0 of the data reaches the request; channel field is ignored.
	task automatic test_access_request();
		send_access(make_cmd(OP_WRITE_REQ, CH_TOP, 32'hFFFF_FFFE));
		send_access(make_cmd(OP_WRITE_REQ, 4'd5, 32'd1));
		send_access(make_cmd(OP_READ_READY, CH_TOP, 32'd0));
		send_access(make_cmd(OP_WRITE_REQ, 4'd0, 32'hFFFF_FFFE));
	endtask

	// Random traffic: each phase picks back-to-back or gappy sending at
	// random, and channels are often drawn from a small hot set so that
	// set, clear and mask accesses pile up on the same words.
	task automatic test_random_traffic();
		logic [3:0] op;
		logic [3:0] ch;
		logic [31:0] data;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			op = random_opcode();
			ch = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 3))
				: 4'($urandom_range(0, CH_TOP));
			data = random_word();
			send_access(make_cmd(op, ch, data));
		end
		no_idle = 1'b0;
	endtask

	// Checker and predictor: at each rising edge, first match a shown
	// result against the oldest expectation, then predict the access that
	// this edge transfers. Both read values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					report_mismatch("result with nothing outstanding", result.read_data, 32'd0);
				end else begin
					want_reply = pending_replies.pop_front();
					if (result.read_data !== want_reply.read_data)
						report_mismatch("read_data", result.read_data, want_reply.read_data);
					if (result.interrupt_pending !== want_reply.interrupt_pending)
						report_mismatch("interrupt_pending", 32'(result.interrupt_pending),
							32'(want_reply.interrupt_pending));
					if (result.request_flag !== want_reply.request_flag)
						report_mismatch("request_flag", 32'(result.request_flag),
							32'(want_reply.request_flag));
				end
			end
			if (start && !busy)
				pending_replies.push_back(apply_access(cmd));
		end
	end

	// Watchdog: count cycles with neither an access nor a result transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("mailbox_doorbell_registers_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			status_copy[k] = '0;
			mask_copy[k] = '0;
		end
		request_copy = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = make_cmd(OP_READ_STATUS, 4'd0, 32'd0);
		// Hold reset, then release it on a falling edge.
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_status_and_mask();
		test_access_request();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		// Drain: wait out every result, then watch a few more cycles for
		// anything unexpected.
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("mailbox_doorbell_registers_unit_tb passed");
		else
			$display("mailbox_doorbell_registers_unit_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/mdr_pkg.sv
design/mdr_ctrl.sv
design/mdr_datapath.sv
design/mailbox_doorbell_registers_unit.sv
sim/mailbox_doorbell_registers_unit_tb.sv
